### rtl/paik_pkg.sv
// Shared types, widths and constants for the planar arm inverse kinematics unit.
// No dependencies; every other file except paik_ifs imports this package.
package paik_pkg;

  localparam int ITERS       = 20;
  localparam int QDEPTH      = 4;
  localparam int NORM_STAGES = 6;
  localparam int VEC_LAT     = NORM_STAGES + ITERS + 2;

  localparam int RX_W  = 33;
  localparam int Z_W   = 34;
  localparam int VIN_W = 51;
  localparam int VW    = 54;
  localparam int Q_W   = 31;
  localparam int SQ_W  = 62;

  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] ANGLE_PI     = 16'h8000;

  typedef enum logic [1:0] {
    REG_BASE,
    REG_UPPER,
    REG_FORE,
    REG_HAND
  } reg_idx_t;

  typedef logic [14:0] len_t;

  typedef struct packed {
    len_t base;
    len_t upper;
    len_t fore;
    len_t hand;
  } lengths_t;

  typedef struct packed {
    logic [15:0]        h;
    logic signed [16:0] xp;
    logic signed [16:0] yp;
  } pose_t;

  function automatic logic [Z_W-1:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      default: v = 32'h0;
    endcase
    return {2'b00, v};
  endfunction

endpackage

### rtl/paik_ifs.sv
// Valid/ready channel interfaces: target pose in, joint angles out, length writes.
// Plain signals only; no package dependency.
interface paik_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_heading;
  modport source(output valid, target_x, target_y, target_heading, input ready);
  modport sink(input valid, target_x, target_y, target_heading, output ready);
endinterface

interface paik_joint_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shoulder_angle;
  logic signed [15:0] elbow_angle;
  logic signed [15:0] wrist_angle;
  logic               unreachable;
  modport source(output valid, shoulder_angle, elbow_angle, wrist_angle, unreachable,
                 input ready);
  modport sink(input valid, shoulder_angle, elbow_angle, wrist_angle, unreachable,
               output ready);
endinterface

interface paik_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/paik_front.sv
// Front end: length registers, pose acceptance and base-frame rotation.
// Depends on paik_pkg and paik_ifs.
module paik_front (
  input  logic              clk,
  input  logic              rst,
  paik_pose_if.sink         pose,
  paik_cfg_if.sink          cfg,
  input  logic              full,
  output logic              push,
  output paik_pkg::pose_t   item,
  output paik_pkg::lengths_t lengths
);
  import paik_pkg::*;

  assign cfg.ready  = 1'b1;
  assign pose.ready = !full;
  assign push       = pose.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      lengths.base  <= 15'd410;
      lengths.upper <= 15'd4096;
      lengths.fore  <= 15'd4096;
      lengths.hand  <= 15'd4096;
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_BASE:  lengths.base  <= cfg.data;
        REG_UPPER: lengths.upper <= cfg.data;
        REG_FORE:  lengths.fore  <= cfg.data;
        REG_HAND:  lengths.hand  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.xp = {pose.target_y[15], pose.target_y} - {2'b00, lengths.base};
    item.yp = 17'd0 - {pose.target_x[15], pose.target_x};
    item.h  = pose.target_heading - QUARTER_TURN;
  end

endmodule

### rtl/paik_queue.sv
// Short pose queue between front end and solver pipeline.
// Depends on paik_pkg.
module paik_queue #(
  parameter int DEPTH = paik_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  paik_pkg::pose_t wr,
  input  logic            pop,
  output paik_pkg::pose_t rd,
  output logic            full,
  output logic            empty
);
  import paik_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pose_t          mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rd    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/paik_vec.sv
// Pipelined atan2: normalizing shifter, half-plane fold and vectoring CORDIC.
// Depends on paik_pkg; every stage advances only while en is high.
module paik_vec (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [paik_pkg::VIN_W-1:0]   x_in,
  input  logic signed [paik_pkg::VIN_W-1:0]   y_in,
  output logic [15:0]                         angle
);
  import paik_pkg::*;

  logic signed [VIN_W-1:0] nx [NORM_STAGES];
  logic signed [VIN_W-1:0] ny [NORM_STAGES];
  logic [VEC_LAT-2:0]      zs;
  logic signed [VW-1:0]    cx [ITERS+1];
  logic signed [VW-1:0]    cy [ITERS+1];
  logic signed [Z_W-1:0]   cz [ITERS+1];
  logic [31:0]             zr;

  always_ff @(posedge clk) begin
    if (en) zs <= {zs[VEC_LAT-3:0], (x_in == '0) && (y_in == '0)};
  end

  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_norm
    localparam int SH = 32 >> s;
    localparam logic signed [VIN_W-1:0] LIM = VIN_W'(longint'(1) << (41 - SH));
    logic signed [VIN_W-1:0] sx, sy;
    logic                    small_xy;
    if (s == 0) begin : g_first
      assign sx = x_in;
      assign sy = y_in;
    end else begin : g_rest
      assign sx = nx[s-1];
      assign sy = ny[s-1];
    end
    assign small_xy = (sx < LIM) && (sx > -LIM) && (sy < LIM) && (sy > -LIM);
    always_ff @(posedge clk) begin
      if (en) begin
        nx[s] <= small_xy ? (sx <<< SH) : sx;
        ny[s] <= small_xy ? (sy <<< SH) : sy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (nx[NORM_STAGES-1] < 0) begin
        cx[0] <= -VW'(nx[NORM_STAGES-1]);
        cy[0] <= -VW'(ny[NORM_STAGES-1]);
        cz[0] <= Z_W'(64'sh80000000);
      end else begin
        cx[0] <= VW'(nx[NORM_STAGES-1]);
        cy[0] <= VW'(ny[NORM_STAGES-1]);
        cz[0] <= '0;
      end
    end
  end

  for (genvar it = 0; it < ITERS; it++) begin : g_iter
    logic signed [VW-1:0] dx, dy;
    assign dx = cy[it] >>> it;
    assign dy = cx[it] >>> it;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[it] >= 0) begin
          cx[it+1] <= cx[it] + dx;
          cy[it+1] <= cy[it] - dy;
          cz[it+1] <= cz[it] + signed'(atan_val(it));
        end else begin
          cx[it+1] <= cx[it] - dx;
          cy[it+1] <= cy[it] + dy;
          cz[it+1] <= cz[it] - signed'(atan_val(it));
        end
      end
    end
  end

  assign zr = cz[ITERS][31:0] + 32'h8000;

  always_ff @(posedge clk) begin
    if (en) angle <= zs[VEC_LAT-2] ? 16'h0 : zr[31:16];
  end

endmodule

### rtl/paik_back.sv
// Solver pipeline: wrist point, law of cosines divide, square root and joint angles.
// Depends on paik_pkg, paik_ifs and paik_vec.
module paik_back (
  input  logic               clk,
  input  logic               rst,
  input  paik_pkg::lengths_t lengths,
  input  logic               empty,
  input  paik_pkg::pose_t    rd,
  output logic               pop,
  paik_joint_if.source       joints
);
  import paik_pkg::*;

  localparam int S_ROTE = ITERS;
  localparam int S_MUL  = S_ROTE + 1;
  localparam int S_UV   = S_MUL + 1;
  localparam int S_SQ   = S_UV + 1;
  localparam int S_NUM  = S_SQ + 1;
  localparam int S_CLS  = S_NUM + 1;
  localparam int S_DIVE = S_CLS + Q_W;
  localparam int S_C2   = S_DIVE + 1;
  localparam int S_CSQ  = S_C2 + 1;
  localparam int S_SR0  = S_CSQ + 1;
  localparam int S_SRE  = S_SR0 + Q_W;
  localparam int S_K1   = S_SRE + 1;
  localparam int S_K2   = S_K1 + 1;
  localparam int S_K3   = S_K2 + 1;
  localparam int S_K4   = S_K3 + 1;
  localparam int LAST   = S_K4 + VEC_LAT;
  localparam int NST    = LAST + 1;

  typedef struct packed {
    logic [15:0]        h;
    logic signed [16:0] xp;
    logic signed [16:0] yp;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic               unr;
    logic               neg;
    logic signed [31:0] c2;
    logic [30:0]        s2;
  } side_t;

  logic            en;
  logic [NST-1:0]  vld;
  side_t           sd  [NST];
  side_t           sdn [NST];

  logic              ovalid;
  logic signed [15:0] oshoulder, oelbow, owrist;
  logic               ounr;

  logic signed [15:0] a2s, a3s;
  logic [29:0]        a1sq, a2sq;
  logic [30:0]        asum, den_r;

  logic signed [RX_W-1:0] rx [ITERS+1];
  logic signed [RX_W-1:0] ry [ITERS+1];
  logic signed [Z_W-1:0]  rz [ITERS+1];
  logic                   rf [ITERS+1];
  logic [31:0]            ang0;
  logic                   flip0;

  logic signed [RX_W-1:0] chv, shv;
  logic signed [48:0]     pc, ps, tc, ts;
  logic signed [35:0]     uu, vv;
  logic signed [36:0]     num;
  logic [36:0]            nm;

  logic [31:0]      drem [Q_W+1];
  logic [Q_W-1:0]   dq   [Q_W];

  logic signed [63:0] csq;
  logic [SQ_W-1:0]    sn [Q_W+1];
  logic [SQ_W-1:0]    sr [Q_W+1];

  logic signed [47:0] pk1, pk2;
  logic signed [48:0] k1w, k2w;
  logic signed [31:0] k1, k2;
  logic signed [49:0] uk1, vk2, vk1, uk2;
  logic signed [VIN_W-1:0] vx, vy, c2x, s2y;
  logic [15:0]        q1, q2;

  assign en  = !ovalid || joints.ready;
  assign pop = en && !empty;

  assign joints.valid          = ovalid;
  assign joints.shoulder_angle = oshoulder;
  assign joints.elbow_angle    = oelbow;
  assign joints.wrist_angle    = owrist;
  assign joints.unreachable    = ounr;

  assign a2s = signed'({1'b0, lengths.fore});
  assign a3s = signed'({1'b0, lengths.hand});

  always_ff @(posedge clk) begin
    a1sq  <= lengths.upper * lengths.upper;
    a2sq  <= lengths.fore * lengths.fore;
    asum  <= {1'b0, a1sq} + {1'b0, a2sq};
    den_r <= {30'(lengths.upper * lengths.fore), 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], pop};
  end

  assign tc  = (pc + (49'sd1 <<< 29)) >>> 30;
  assign ts  = (ps + (49'sd1 <<< 29)) >>> 30;

  always_comb begin
    for (int i = 1; i < NST; i++) sdn[i] = sd[i-1];
    sdn[0]      = '0;
    sdn[0].h    = rd.h;
    sdn[0].xp   = rd.xp;
    sdn[0].yp   = rd.yp;
    sdn[S_UV].u = {sd[S_MUL].xp[16], sd[S_MUL].xp} - tc[17:0];
    sdn[S_UV].v = {sd[S_MUL].yp[16], sd[S_MUL].yp} - ts[17:0];
    sdn[S_CLS].neg = num[36];
    sdn[S_CLS].unr = (nm > {6'b0, den_r}) || (den_r == '0);
    if (sd[S_DIVE].unr) begin
      sdn[S_C2].c2 = sd[S_DIVE].neg ? -32'sd1073741824 : 32'sd1073741824;
    end else begin
      sdn[S_C2].c2 = sd[S_DIVE].neg ? -signed'({1'b0, dq[Q_W-1]}) : signed'({1'b0, dq[Q_W-1]});
    end
    sdn[S_K1].s2 = sr[Q_W][30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) sd[i] <= sdn[i];
    end
  end

  assign ang0  = {rd.h, 16'h0};
  assign flip0 = ang0[31] ^ ang0[30];

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= RX_W'(CORDIC_GAIN);
      ry[0] <= '0;
      rf[0] <= flip0;
      rz[0] <= {{2{ang0[31] ^ flip0}}, ang0[31] ^ flip0, ang0[30:0]};
    end
  end

  for (genvar it = 0; it < ITERS; it++) begin : g_rot
    logic signed [RX_W-1:0] dx, dy;
    assign dx = ry[it] >>> it;
    assign dy = rx[it] >>> it;
    always_ff @(posedge clk) begin
      if (en) begin
        rf[it+1] <= rf[it];
        if (rz[it] >= 0) begin
          rx[it+1] <= rx[it] - dx;
          ry[it+1] <= ry[it] + dy;
          rz[it+1] <= rz[it] - signed'(atan_val(it));
        end else begin
          rx[it+1] <= rx[it] + dx;
          ry[it+1] <= ry[it] - dy;
          rz[it+1] <= rz[it] + signed'(atan_val(it));
        end
      end
    end
  end

  assign chv = rf[ITERS] ? -rx[ITERS] : rx[ITERS];
  assign shv = rf[ITERS] ? -ry[ITERS] : ry[ITERS];
  assign nm  = num[36] ? 37'(-num) : 37'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      pc      <= a3s * chv;
      ps      <= a3s * shv;
      uu      <= sd[S_UV].u * sd[S_UV].u;
      vv      <= sd[S_UV].v * sd[S_UV].v;
      num     <= 37'(uu) + 37'(vv) - signed'({6'b0, asum});
      drem[0] <= nm[31:0];
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [31:0]    rin;
    logic [Q_W-1:0] qin;
    logic           ge;
    if (j == 0) begin : g_first
      assign rin = drem[j];
      assign qin = '0;
    end else begin : g_rest
      assign rin = {drem[j][30:0], 1'b0};
      assign qin = dq[j-1];
    end
    assign ge = rin >= {1'b0, den_r};
    always_ff @(posedge clk) begin
      if (en) begin
        drem[j+1] <= ge ? rin - {1'b0, den_r} : rin;
        dq[j]     <= {qin[Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      csq   <= sd[S_C2].c2 * sd[S_C2].c2;
      sn[0] <= (SQ_W'(1) << 60) - csq[SQ_W-1:0];
      sr[0] <= '0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] t;
    assign t = sr[k] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sn[k] >= t) begin
          sn[k+1] <= sn[k] - t;
          sr[k+1] <= (sr[k] >> 1) + BITV;
        end else begin
          sn[k+1] <= sn[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  assign k1w = signed'({4'b0, lengths.upper, 30'b0}) + 49'(pk1) + 49'sd32768;
  assign k2w = 49'(pk2) + 49'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      pk1 <= a2s * sd[S_SRE].c2;
      pk2 <= a2s * signed'({1'b0, sr[Q_W][30:0]});
      k1  <= 32'(k1w >>> 16);
      k2  <= 32'(k2w >>> 16);
      uk1 <= sd[S_K2].u * k1;
      vk2 <= sd[S_K2].v * k2;
      vk1 <= sd[S_K2].v * k1;
      uk2 <= sd[S_K2].u * k2;
      vx  <= 51'(uk1) + 51'(vk2);
      vy  <= 51'(vk1) - 51'(uk2);
    end
  end

  assign c2x = VIN_W'(sd[S_K4].c2);
  assign s2y = signed'(VIN_W'({1'b0, sd[S_K4].s2}));

  paik_vec u_vec_shoulder (
    .clk   (clk),
    .en    (en),
    .x_in  (vx),
    .y_in  (vy),
    .angle (q1)
  );

  paik_vec u_vec_elbow (
    .clk   (clk),
    .en    (en),
    .x_in  (c2x),
    .y_in  (s2y),
    .angle (q2)
  );

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (en) ovalid <= vld[LAST];
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAST]) begin
      oshoulder <= q1;
      oelbow    <= q2;
      owrist    <= sd[LAST].h - q1 - q2;
      ounr      <= sd[LAST].unr;
    end
  end

endmodule

### rtl/planar_arm_inverse_kinematics_unit.sv
// Top level of the planar three-joint arm inverse kinematics unit.
// Depends on paik_pkg, paik_ifs, paik_front, paik_queue and paik_back.
//
//   channel  | role   | carries
//   ---------+--------+---------------------------------------------------
//   pose     | sink   | target_x, target_y, target_heading
//   joints   | source | shoulder_angle, elbow_angle, wrist_angle, unreachable
//   cfg      | sink   | index, data (link lengths, always ready)
//
// One pose per cycle sustained while joints.ready is high; a pose transaction reaches
// its result through the 31-step divider, the 31-step square root and the CORDIC chains.
// Reset (synchronous) empties queue and pipeline and restores default lengths.
// joints.ready low while joints.valid is high freezes the solver pipeline; the queue
// absorbs QUEUE_DEPTH poses before pose.ready drops.
module planar_arm_inverse_kinematics_unit #(
  parameter int QUEUE_DEPTH = paik_pkg::QDEPTH
) (
  input logic          clk,
  input logic          rst,
  paik_pose_if.sink    pose,
  paik_cfg_if.sink     cfg,
  paik_joint_if.source joints
);
  import paik_pkg::*;

  logic     full, empty, push, pop;
  pose_t    item, rd;
  lengths_t lengths;

  paik_front u_front (
    .clk     (clk),
    .rst     (rst),
    .pose    (pose),
    .cfg     (cfg),
    .full    (full),
    .push    (push),
    .item    (item),
    .lengths (lengths)
  );

  paik_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr    (item),
    .pop   (pop),
    .rd    (rd),
    .full  (full),
    .empty (empty)
  );

  paik_back u_back (
    .clk     (clk),
    .rst     (rst),
    .lengths (lengths),
    .empty   (empty),
    .rd      (rd),
    .pop     (pop),
    .joints  (joints)
  );

endmodule

### rtl/paik_checker.sv
// Port-level checks for the arm inverse kinematics unit, bound to the top level.
// Depends on paik_pkg.
module paik_checker (
  input logic        clk,
  input logic        rst,
  input logic        pose_valid,
  input logic        pose_ready,
  input logic        joints_valid,
  input logic        joints_ready,
  input logic [15:0] shoulder_angle,
  input logic [15:0] elbow_angle,
  input logic [15:0] wrist_angle,
  input logic        unreachable
);
  import paik_pkg::*;

  logic [8:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = pose_valid && pose_ready;
  assign out_acc = joints_valid && joints_ready;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else if (in_acc && !out_acc) pending <= pending + 1'b1;
    else if (out_acc && !in_acc) pending <= pending - 1'b1;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    joints_valid && !joints_ready |=> joints_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    joints_valid && !joints_ready |=>
      $stable({shoulder_angle, elbow_angle, wrist_angle, unreachable}))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    joints_valid |-> pending != '0)
    else $error("result without a pending pose");

  a_unreach_elbow: assert property (@(posedge clk) disable iff (rst)
    joints_valid && unreachable |-> (elbow_angle == 16'h0) || (elbow_angle == ANGLE_PI))
    else $error("saturated elbow not straight or folded");

endmodule

bind planar_arm_inverse_kinematics_unit paik_checker u_paik_checker (
  .clk            (clk),
  .rst            (rst),
  .pose_valid     (pose.valid),
  .pose_ready     (pose.ready),
  .joints_valid   (joints.valid),
  .joints_ready   (joints.ready),
  .shoulder_angle (joints.shoulder_angle),
  .elbow_angle    (joints.elbow_angle),
  .wrist_angle    (joints.wrist_angle),
  .unreachable    (joints.unreachable)
);

### bench/planar_arm_inverse_kinematics_unit_tb.sv
// Self-checking bench for planar_arm_inverse_kinematics_unit: random and corner poses
// under several link-length settings, checked against a built-in fixed-point solver.
// Depends on rtl/paik_pkg.sv, rtl/paik_ifs.sv and the unit's RTL.
module planar_arm_inverse_kinematics_unit_tb;
  import paik_pkg::*;

  localparam int     LATENCY   = 124;
  localparam int     LIMIT     = 400000;
  localparam int     ITEMS_PER = 370;
  localparam longint Q30       = 64'sd1073741824;
  localparam longint ATAN_Q32 [20] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517};

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] heading;
  } target_t;

  typedef struct {
    logic [15:0] shoulder;
    logic [15:0] elbow;
    logic [15:0] wrist;
    logic        unr;
  } joints_t;

  logic clk;
  logic rst;
  paik_pose_if  pose();
  paik_cfg_if   cfg();
  paik_joint_if joints();

  planar_arm_inverse_kinematics_unit dut (
    .clk(clk), .rst(rst), .pose(pose), .cfg(cfg), .joints(joints)
  );

  target_t targets_pending[$];
  joints_t joints_expected[$];
  len_t    arm_len [4];
  int      errors;
  int      poses_sent;
  int      joints_seen;
  int      unreach_seen;
  int      cycles;
  bit      took;
  bit      steady;
  bit      stall_req;
  int      hold_left;

  function automatic void cordic_rotate(input logic [31:0] ang, output longint c,
                                        output longint s);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = 64'sd652032874;
    y = 0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      flip = 1;
      ang = ang + 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q32[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q32[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] cordic_atan2(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 32'd0;
    while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
      x *= 2; y *= 2;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q32[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q32[i];
      end
    end
    return z[31:0];
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h8000;
    return r[31:16];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic joints_t solve_pose(input target_t t);
    joints_t     j;
    logic [15:0] h;
    longint      xp, yp, a1, a2, a3, ch, sh, u, v, num, den, c2, s2, k1, k2;
    h  = t.heading - QUARTER_TURN;
    xp = longint'($signed(t.y)) - longint'(arm_len[REG_BASE]);
    yp = -longint'($signed(t.x));
    a1 = arm_len[REG_UPPER];
    a2 = arm_len[REG_FORE];
    a3 = arm_len[REG_HAND];
    cordic_rotate({h, 16'h0000}, ch, sh);
    u = xp - ((a3 * ch + (64'sd1 <<< 29)) >>> 30);
    v = yp - ((a3 * sh + (64'sd1 <<< 29)) >>> 30);
    num = u * u + v * v - a1 * a1 - a2 * a2;
    den = 2 * a1 * a2;
    j.unr = 0;
    if ((num < 0 ? -num : num) > den || den == 0) begin
      j.unr = 1;
      c2 = num < 0 ? -Q30 : Q30;
    end else begin
      c2 = (num * Q30) / den;
    end
    s2 = longint'(floor_sqrt(longint'(Q30 * Q30 - c2 * c2)));
    j.elbow = round_angle(cordic_atan2(c2, s2));
    k1 = (a1 * Q30 + a2 * c2 + (64'sd1 <<< 15)) >>> 16;
    k2 = (a2 * s2 + (64'sd1 <<< 15)) >>> 16;
    j.shoulder = round_angle(cordic_atan2(u * k1 + v * k2, v * k1 - u * k2));
    j.wrist = h - j.shoulder - j.elbow;
    return j;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("planar_arm_inverse_kinematics_unit: mismatch");
      $finish;
    end
  end

  // pose driver
  always @(posedge clk) begin
    if (!rst && pose.valid && pose.ready) begin
      joints_expected.push_back(solve_pose(targets_pending.pop_front()));
      poses_sent++;
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pose.valid <= 0;
    end else if (!pose.valid || took) begin
      took = 0;
      if (targets_pending.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
        pose.valid          <= 1;
        pose.target_x       <= targets_pending[0].x;
        pose.target_y       <= targets_pending[0].y;
        pose.target_heading <= targets_pending[0].heading;
      end else begin
        pose.valid <= 0;
      end
    end
  end

  // joint monitor
  always @(negedge clk) begin
    if (rst) begin
      joints.ready <= 0;
    end else if (stall_req) begin
      stall_req = 0;
      hold_left = 400;
      joints.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      joints.ready <= 0;
    end else begin
      joints.ready <= steady || $urandom_range(99) >= 33;
    end
  end

  always @(posedge clk) begin
    joints_t e;
    if (!rst && joints.valid && joints.ready) begin
      joints_seen++;
      if (joints_expected.size() == 0) begin
        errors++;
        $display("%0t unexpected result: got %h %h %h %b", $time, joints.shoulder_angle,
                 joints.elbow_angle, joints.wrist_angle, joints.unreachable);
      end else begin
        e = joints_expected.pop_front();
        unreach_seen += e.unr;
        if (joints.shoulder_angle !== e.shoulder || joints.elbow_angle !== e.elbow ||
            joints.wrist_angle !== e.wrist || joints.unreachable !== e.unr) begin
          errors++;
          $display("%0t expected %h %h %h %b, actual %h %h %h %b", $time, e.shoulder,
                   e.elbow, e.wrist, e.unr, joints.shoulder_angle, joints.elbow_angle,
                   joints.wrist_angle, joints.unreachable);
        end
      end
    end
  end

  task automatic write_length(input reg_idx_t idx, input len_t value);
    @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    arm_len[idx] = value;
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic set_lengths(input len_t b, input len_t up, input len_t fo, input len_t ha);
    write_length(REG_BASE, b);
    write_length(REG_UPPER, up);
    write_length(REG_FORE, fo);
    write_length(REG_HAND, ha);
  endtask

  task automatic add_target(input int x, input int y, input int heading);
    target_t t;
    t.x = x;
    t.y = y;
    t.heading = heading;
    targets_pending.push_back(t);
  endtask

  task automatic add_random(input int n);
    int span;
    for (int i = 0; i < n; i++) begin
      span = arm_len[REG_UPPER] + arm_len[REG_FORE] + arm_len[REG_HAND] + 512;
      if (span > 32767) span = 32767;
      if ($urandom_range(99) < 70)
        add_target($urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span + arm_len[REG_BASE],
                   $urandom_range(65535));
      else
        add_target($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    end
  endtask

  task automatic drain();
    while (targets_pending.size() > 0 || pose.valid || joints_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    pose.valid = 0;
    pose.target_x = 0;
    pose.target_y = 0;
    pose.target_heading = 0;
    cfg.valid = 0;
    cfg.index = REG_BASE;
    cfg.data = 0;
    joints.ready = 0;
    errors = 0;
    poses_sent = 0;
    joints_seen = 0;
    unreach_seen = 0;
    cycles = 0;
    took = 0;
    steady = 0;
    stall_req = 0;
    hold_left = 0;
    arm_len[REG_BASE]  = 410;
    arm_len[REG_UPPER] = 4096;
    arm_len[REG_FORE]  = 4096;
    arm_len[REG_HAND]  = 4096;
    repeat (11) @(negedge clk);
    rst = 0;

    add_target(0, 0, 0);
    add_target(32767, 32767, 32767);
    add_target(-32768, -32768, -32768);
    add_target(-32768, 32767, 0);
    add_target(32767, -32768, 16384);
    add_target(4000, 2000, -16384);
    add_target(-3000, 5000, 8000);
    add_target(0, 410 + 8192, 16384);
    add_target(1, -1, 65535 - 65536);
    add_random(ITEMS_PER);
    drain();

    set_lengths(410, 4096, 4096, 0);
    add_target(0, 410, 0);
    add_target(0, 410 + 8192, 12345);
    add_target(0, 410 + 8193, -12345);
    add_target(8192, 410, 16384);
    steady = 1;
    add_random(ITEMS_PER);
    drain();
    steady = 0;

    set_lengths(32767, 32767, 32767, 32767);
    add_random(ITEMS_PER);
    stall_req = 1;
    drain();

    set_lengths(0, 1, 1, 0);
    add_target(0, 0, 0);
    add_target(1, 1, 16384);
    add_random(ITEMS_PER);
    drain();

    set_lengths(0, 0, 0, 100);
    add_target(0, 0, 16384);
    add_random(40);
    drain();

    set_lengths($urandom_range(32767), 1 + $urandom_range(16000), 1 + $urandom_range(16000),
                $urandom_range(8000));
    add_random(ITEMS_PER - 40);
    drain();

    $display("covered %0d poses over six length settings, %0d results, %0d out of reach",
             poses_sent, joints_seen, unreach_seen);
    if (errors == 0) begin
      $display("planar_arm_inverse_kinematics_unit: match");
    end else begin
      $display("planar_arm_inverse_kinematics_unit: mismatch");
    end
    $finish;
  end
endmodule

### files.f
rtl/paik_pkg.sv
rtl/paik_ifs.sv
rtl/paik_front.sv
rtl/paik_queue.sv
rtl/paik_vec.sv
rtl/paik_back.sv
rtl/planar_arm_inverse_kinematics_unit.sv
rtl/paik_checker.sv
bench/planar_arm_inverse_kinematics_unit_tb.sv
